FILE: design/owrs_pkg.sv
// Shared types and constants for the 1-Wire ROM search engine.
// No dependencies.
package owrs_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_BEGIN    = 2'd1,
        OP_BIT_PAIR = 2'd2
    } op_t;

    // Zero choices at positions below this limit fall in the family byte.
    localparam int unsigned FAMILY_LIMIT = 9;
    localparam int unsigned FAMILY_W     = 4;
    localparam int unsigned FIRST_BYTE_W = 8;

    typedef struct packed {
        logic write_valid;
        logic write_bit;
        logic pass_done;
        logic found;
        logic last_device;
        logic ignored;
    } flags_t;

endpackage

FILE: design/owrs_engine.sv
// Search state and per-request update logic of the ROM search.
// Depends on owrs_pkg.
module owrs_engine #(
    parameter int unsigned ID_BITS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  logic [1:0]                  opcode,
    input  logic                        presence,
    input  logic                        id_bit,
    input  logic                        complement_bit,
    output owrs_pkg::flags_t            flags,
    output logic [ID_BITS-1:0]          rom_id,
    output logic [owrs_pkg::FAMILY_W-1:0] family_discrepancy
);

    localparam int unsigned POS_W = $clog2(ID_BITS + 2);
    localparam int unsigned IDX_W = $clog2(ID_BITS);
    localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(ID_BITS);
    localparam logic [POS_W-1:0] POS_FAM  = POS_W'(owrs_pkg::FAMILY_LIMIT);

    logic [ID_BITS-1:0]            rom_reg, rom_next;
    logic [POS_W-1:0]              ldp_reg, ldp_next;
    logic                          last_dev_reg, last_dev_next;
    logic [owrs_pkg::FAMILY_W-1:0] fam_reg, fam_next;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic [POS_W-1:0]              plz_reg, plz_next;
    logic                          active_reg, active_next;

    logic [IDX_W-1:0] idx;
    logic             dir;
    owrs_pkg::op_t    op;

    assign op  = owrs_pkg::op_t'(opcode);
    assign idx = IDX_W'(pos_reg - POS_ONE);

    always_comb
    begin
        rom_next      = rom_reg;
        ldp_next      = ldp_reg;
        last_dev_next = last_dev_reg;
        fam_next      = fam_reg;
        pos_next      = pos_reg;
        plz_next      = plz_reg;
        active_next   = active_reg;
        flags         = '0;
        dir           = 1'b0;

        unique case (op)
            owrs_pkg::OP_CLEAR:
            begin
                rom_next      = '0;
                ldp_next      = '0;
                last_dev_next = 1'b0;
                fam_next      = '0;
                pos_next      = POS_ONE;
                plz_next      = '0;
                active_next   = 1'b0;
            end
            owrs_pkg::OP_BEGIN:
            begin
                pos_next    = POS_ONE;
                plz_next    = '0;
                active_next = 1'b0;
                if (last_dev_reg || !presence)
                begin
                    ldp_next        = '0;
                    last_dev_next   = 1'b0;
                    fam_next        = '0;
                    flags.pass_done = 1'b1;
                end
                else
                begin
                    active_next = 1'b1;
                end
            end
            owrs_pkg::OP_BIT_PAIR:
            begin
                if (!active_reg)
                begin
                    flags.ignored = 1'b1;
                end
                else if (id_bit && complement_bit)
                begin
                    // no device answered this bit: abandon the pass
                    active_next     = 1'b0;
                    pos_next        = POS_ONE;
                    ldp_next        = '0;
                    last_dev_next   = 1'b0;
                    fam_next        = '0;
                    flags.pass_done = 1'b1;
                end
                else
                begin
                    if (id_bit != complement_bit)
                        dir = id_bit;
                    else if (pos_reg < ldp_reg)
                        dir = rom_reg[idx];
                    else
                        dir = (pos_reg == ldp_reg);

                    if ((id_bit == complement_bit) && !dir)
                    begin
                        plz_next = pos_reg;
                        if (pos_reg < POS_FAM)
                            fam_next = owrs_pkg::FAMILY_W'(pos_reg);
                    end

                    rom_next[idx]     = dir;
                    flags.write_valid = 1'b1;
                    flags.write_bit   = dir;

                    if (pos_reg == POS_LAST)
                    begin
                        active_next     = 1'b0;
                        pos_next        = POS_ONE;
                        flags.pass_done = 1'b1;
                        ldp_next        = plz_next;
                        last_dev_next   = (plz_next == '0) ? 1'b1 : last_dev_reg;
                        flags.found     = 1'b1;
                        if (rom_next[owrs_pkg::FIRST_BYTE_W-1:0] == '0)
                        begin
                            ldp_next      = '0;
                            last_dev_next = 1'b0;
                            fam_next      = '0;
                            flags.found   = 1'b0;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + POS_ONE;
                    end
                end
            end
            default:
            begin
                // unused opcode: no state change, all flags low except last_device, which shows the kept state
            end
        endcase

        flags.last_device  = last_dev_next;
        rom_id             = rom_next;
        family_discrepancy = fam_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_reg      <= '0;
            ldp_reg      <= '0;
            last_dev_reg <= 1'b0;
            fam_reg      <= '0;
            pos_reg      <= POS_ONE;
            plz_reg      <= '0;
            active_reg   <= 1'b0;
        end
        else if (fire)
        begin
            rom_reg      <= rom_next;
            ldp_reg      <= ldp_next;
            last_dev_reg <= last_dev_next;
            fam_reg      <= fam_next;
            pos_reg      <= pos_next;
            plz_reg      <= plz_next;
            active_reg   <= active_next;
        end
    end

endmodule

FILE: design/onewire_rom_search.sv
// 1-Wire ROM search engine, top level: request register, engine, result register.
// Depends on owrs_pkg and owrs_engine.
//
// Each request (clear, begin pass with presence, or one bit pair read from the
// bus) yields exactly one result. A request is held in the request register, is
// applied to the search state, and its result lands in the result register;
// one request is taken every cycle while the request side does not stall. The
// engine state is written together with the result register, so a request sees
// everything left by the one before it. The request side stalls only while a
// request is held and the result register is full and stalled.
module onewire_rom_search #(
    parameter int unsigned ID_BITS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [1:0]                    opcode,
    input  logic                          presence,
    input  logic                          id_bit,
    input  logic                          complement_bit,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic                          write_valid,
    output logic                          write_bit,
    output logic                          pass_done,
    output logic                          found,
    output logic                          last_device,
    output logic [ID_BITS-1:0]            rom_id,
    output logic [owrs_pkg::FAMILY_W-1:0] family_discrepancy,
    output logic                          ignored
);

    logic       req_valid_reg;
    logic [1:0] opcode_reg;
    logic       presence_reg;
    logic       id_bit_reg;
    logic       complement_bit_reg;

    logic                          res_valid_reg;
    owrs_pkg::flags_t              flags_reg;
    logic [ID_BITS-1:0]            rom_id_reg;
    logic [owrs_pkg::FAMILY_W-1:0] family_reg;

    owrs_pkg::flags_t              eng_flags;
    logic [ID_BITS-1:0]            eng_rom_id;
    logic [owrs_pkg::FAMILY_W-1:0] eng_family;

    logic res_free;
    logic fire;
    logic req_take;

    assign res_free  = !res_valid_reg || !res_stall;
    assign fire      = req_valid_reg && res_free;
    assign req_stall = req_valid_reg && !res_free;
    assign req_take  = req_valid && !req_stall;

    owrs_engine #(
        .ID_BITS(ID_BITS)
    ) u_engine (
        .clk                (clk),
        .rst_n              (rst_n),
        .fire               (fire),
        .opcode             (opcode_reg),
        .presence           (presence_reg),
        .id_bit             (id_bit_reg),
        .complement_bit     (complement_bit_reg),
        .flags              (eng_flags),
        .rom_id             (eng_rom_id),
        .family_discrepancy (eng_family)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_take)
                req_valid_reg <= 1'b1;
            else if (fire)
                req_valid_reg <= 1'b0;

            if (fire)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            opcode_reg         <= opcode;
            presence_reg       <= presence;
            id_bit_reg         <= id_bit;
            complement_bit_reg <= complement_bit;
        end
        if (fire)
        begin
            flags_reg  <= eng_flags;
            rom_id_reg <= eng_rom_id;
            family_reg <= eng_family;
        end
    end

    assign res_valid          = res_valid_reg;
    assign write_valid        = flags_reg.write_valid;
    assign write_bit          = flags_reg.write_bit;
    assign pass_done          = flags_reg.pass_done;
    assign found              = flags_reg.found;
    assign last_device        = flags_reg.last_device;
    assign ignored            = flags_reg.ignored;
    assign rom_id             = rom_id_reg;
    assign family_discrepancy = family_reg;

endmodule
